// ===== hdl/phc_pkg.sv =====
`default_nettype none
package phc_pkg;

	// presence codes
	typedef enum logic [1:0] {
		PRES_UNKNOWN  = 2'd0,
		PRES_VACANT   = 2'd1,
		PRES_OCCUPIED = 2'd2
	} presence_t;

	// classification of one window by the front end
	typedef enum logic [1:0] {
		ITEM_UNORDERED = 2'd0,
		ITEM_BAD       = 2'd1,
		ITEM_GOOD      = 2'd2
	} item_kind_t;

	// configuration register indexes
	localparam int CfgIndexW = 3;
	localparam logic [CfgIndexW-1:0] CFG_VACANT_LEVEL   = 3'd0;
	localparam logic [CfgIndexW-1:0] CFG_OCCUPIED_LEVEL = 3'd1;
	localparam logic [CfgIndexW-1:0] CFG_VARIANCE_GAIN  = 3'd2;
	localparam logic [CfgIndexW-1:0] CFG_CV_GAIN        = 3'd3;
	localparam logic [CfgIndexW-1:0] CFG_CONFIRM_COUNT  = 3'd4;
	localparam logic [CfgIndexW-1:0] CFG_LEAST_SAMPLES  = 3'd5;
	localparam logic [CfgIndexW-1:0] CFG_LEAST_RSSI     = 3'd6;
	localparam int CfgDataW = 32;

	// score arithmetic
	localparam logic [15:0] WEIGHT_VAR = 16'd42598;
	localparam logic [15:0] WEIGHT_CV  = 16'd22938;
	localparam logic [16:0] SCORE_ONE  = 17'd65536;
	localparam logic [17:0] PART_CAP   = 18'd131072;

	// queue between front and back
	localparam int MidDepth = 4;
	localparam int MidAw    = $clog2(MidDepth);
	localparam int MidCw    = $clog2(MidDepth + 1);

	// result buffer
	localparam int OutDepth = 2;
	localparam int OutCw    = $clog2(OutDepth + 1);

	typedef struct packed {
		logic [31:0]        window_variance;
		logic [23:0]        window_cv;
		logic               quality_invalid;
		logic [15:0]        sample_total;
		logic signed [7:0]  signal_rssi;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		presence_t          presence;
		logic [16:0]        activity_score;
	} out_item_t;

	typedef struct packed {
		logic [16:0]        vacant_level;
		logic [16:0]        occupied_level;
		logic [31:0]        variance_gain;
		logic [23:0]        cv_gain;
		logic [7:0]         confirm_count;
		logic [15:0]        least_samples;
		logic signed [7:0]  least_rssi;
	} cfg_t;

	typedef struct packed {
		item_kind_t         kind;
		logic [16:0]        score;
	} mid_item_t;

	typedef struct packed {
		logic [MidCw-1:0]   occ;
	} front_stat_t;

	typedef struct packed {
		logic [MidCw-1:0]   count;
	} mid_stat_t;

endpackage
`default_nettype wire

// ===== hdl/presence_hysteresis_classifier_core.sv =====
`default_nettype none
// channel   signals                                  transaction when
// input     push, full, window                       push && !full
// result    empty, pop, result                       pop && !empty
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// one window per cycle is taken while the front credit count (stage 1 plus
// the four-entry queue) has room; the back end retires one item a cycle while
// the result buffer has room; an accepted window loads the product stage,
// then its weighted sum is written into the queue and then its presence update
// into the two-entry result buffer, from which the result is popped
// a stalled result side fills the buffer, then the queue, then raises full
// reset clears state, queue and buffer; config returns to its defaults
module presence_hysteresis_classifier_core import phc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire in_item_t             window,
	output logic                      empty,
	input  wire logic                 pop,
	output out_item_t                 result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	cfg_t        cfg_q;
	logic        mid_wr;
	logic        mid_pop;
	mid_item_t   mid_wr_item;
	mid_item_t   mid_rd_item;
	mid_stat_t   mid_stat;
	front_stat_t front_stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vacant_level   <= 17'd11796;
			cfg_q.occupied_level <= 17'd36045;
			cfg_q.variance_gain  <= 32'd16519105;
			cfg_q.cv_gain        <= 24'd297891;
			cfg_q.confirm_count  <= 8'd2;
			cfg_q.least_samples  <= 16'd8;
			cfg_q.least_rssi     <= -8'sd82;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_VACANT_LEVEL:   cfg_q.vacant_level   <= cfg_data[16:0];
				CFG_OCCUPIED_LEVEL: cfg_q.occupied_level <= cfg_data[16:0];
				CFG_VARIANCE_GAIN:  cfg_q.variance_gain  <= cfg_data;
				CFG_CV_GAIN:        cfg_q.cv_gain        <= cfg_data[23:0];
				CFG_CONFIRM_COUNT:  cfg_q.confirm_count  <= cfg_data[7:0];
				CFG_LEAST_SAMPLES:  cfg_q.least_samples  <= cfg_data[15:0];
				CFG_LEAST_RSSI:     cfg_q.least_rssi     <= $signed(cfg_data[7:0]);
				default: begin
				end
			endcase
		end
	end

	// score and quality front end
	phc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.window   (window),
		.full     (full),
		.cfg      (cfg_q),
		.mid_pop  (mid_pop),
		.mid_wr   (mid_wr),
		.mid_item (mid_wr_item),
		.stat     (front_stat)
	);

	// decoupling queue
	phc_mid_queue u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mid_wr),
		.wr_item (mid_wr_item),
		.rd      (mid_pop),
		.rd_item (mid_rd_item),
		.stat    (mid_stat)
	);

	// presence update back end
	phc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.mid_stat (mid_stat),
		.mid_item (mid_rd_item),
		.mid_pop  (mid_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	// queue never holds more than the front has credited
	a_queue_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		mid_stat.count <= front_stat.occ)
		else $error("queue holds more items than credited");

	// credit never exceeds the queue depth
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.occ <= MidCw'(MidDepth))
		else $error("front credit overrun");

	// a refused window carries no presence and no score
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.accepted) |->
		(result.presence == PRES_UNKNOWN && result.activity_score == '0))
		else $error("refused result not cleared");

	// the score never leaves its range
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.activity_score <= SCORE_ONE)
		else $error("activity score out of range");

	// an empty back end with a waiting item always moves it on
	a_back_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && mid_stat.count != '0) |-> mid_pop)
		else $error("back end stalled with room");

endmodule
`default_nettype wire

// ===== hdl/phc_front.sv =====
`default_nettype none
module phc_front import phc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire in_item_t    window,
	output logic             full,
	input  wire cfg_t        cfg,
	input  wire logic        mid_pop,
	output logic             mid_wr,
	output mid_item_t        mid_item,
	output front_stat_t      stat
);

	logic [63:0]      vprod;
	logic [39:0]      vsh;
	logic [17:0]      vcap;
	logic [47:0]      cprod;
	logic [31:0]      csh;
	logic [17:0]      ccap;
	logic             bad;
	logic             unordered;
	item_kind_t       kind;
	logic             take;

	logic             valid_s1;
	item_kind_t       kind_s1;
	logic [17:0]      vpart_s1;
	logic [17:0]      cpart_s1;

	logic [34:0]      wsum;
	logic [18:0]      ssh;
	logic [16:0]      score;

	logic [MidCw-1:0] occ_q;

	// credits cover the pipeline stage and the queue
	assign full = (occ_q == MidCw'(MidDepth));
	assign take = push && !full;

	// scaled parts, each capped
	always_comb begin
		vprod = 64'(window.window_variance) * 64'(cfg.variance_gain);
		vsh   = vprod[63:24];
		vcap  = (vsh > 40'(PART_CAP)) ? PART_CAP : vsh[17:0];
		cprod = 48'(window.window_cv) * 48'(cfg.cv_gain);
		csh   = cprod[47:16];
		ccap  = (csh > 32'(PART_CAP)) ? PART_CAP : csh[17:0];
	end

	// window quality and level ordering
	always_comb begin
		unordered = (cfg.occupied_level <= cfg.vacant_level);
		bad = window.quality_invalid
			|| (window.sample_total < cfg.least_samples)
			|| ($signed(window.signal_rssi) < $signed(cfg.least_rssi));
		priority if (unordered) begin
			kind = ITEM_UNORDERED;
		end else if (bad) begin
			kind = ITEM_BAD;
		end else begin
			kind = ITEM_GOOD;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1  <= kind;
			vpart_s1 <= vcap;
			cpart_s1 <= ccap;
		end
	end

	// weighted sum and clamp
	always_comb begin
		wsum  = 35'(vpart_s1) * 35'(WEIGHT_VAR) + 35'(cpart_s1) * 35'(WEIGHT_CV);
		ssh   = wsum[34:16];
		score = (ssh > 19'(SCORE_ONE)) ? SCORE_ONE : ssh[16:0];
	end

	assign mid_wr         = valid_s1;
	assign mid_item.kind  = kind_s1;
	assign mid_item.score = score;

	// occupancy of stage and queue together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			unique case ({take, mid_pop})
				2'b10:   occ_q <= occ_q + MidCw'(1);
				2'b01:   occ_q <= occ_q - MidCw'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	assign stat.occ = occ_q;

endmodule
`default_nettype wire

// ===== hdl/phc_mid_queue.sv =====
`default_nettype none
module phc_mid_queue import phc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr,
	input  wire mid_item_t   wr_item,
	input  wire logic        rd,
	output mid_item_t        rd_item,
	output mid_stat_t        stat
);

	mid_item_t        mem_q [MidDepth];
	logic [MidAw-1:0] wptr_q;
	logic [MidAw-1:0] rptr_q;
	logic [MidCw-1:0] count_q;

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + MidAw'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + MidAw'(1);
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + MidCw'(1);
				2'b01:   count_q <= count_q - MidCw'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_item    = mem_q[rptr_q];
	assign stat.count = count_q;

endmodule
`default_nettype wire

// ===== hdl/phc_back.sv =====
`default_nettype none
module phc_back import phc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire mid_stat_t   mid_stat,
	input  wire mid_item_t   mid_item,
	output logic             mid_pop,
	input  wire logic        pop,
	output logic             empty,
	output out_item_t        result
);

	presence_t        current_q;
	presence_t        pending_q;
	logic [7:0]       pend_cnt_q;

	presence_t        current_d;
	presence_t        pending_d;
	logic [7:0]       pend_cnt_d;
	presence_t        target;
	logic [7:0]       need;
	out_item_t        res_d;

	out_item_t        ob_q [OutDepth];
	logic             head_q;
	logic [OutCw-1:0] cnt_q;
	logic             wr_idx;
	logic             take_out;

	assign take_out = pop && !empty;
	assign mid_pop  = (mid_stat.count != '0) && (cnt_q != OutCw'(OutDepth));

	// hysteresis and confirmation
	always_comb begin
		current_d  = current_q;
		pending_d  = pending_q;
		pend_cnt_d = pend_cnt_q;
		target     = current_q;
		need       = (cfg.confirm_count == 8'd0) ? 8'd1 : cfg.confirm_count;
		res_d      = '{accepted: 1'b0, presence: PRES_UNKNOWN, activity_score: '0};
		unique case (mid_item.kind)
			ITEM_BAD: begin
				current_d  = PRES_UNKNOWN;
				pending_d  = PRES_UNKNOWN;
				pend_cnt_d = 8'd0;
				res_d.accepted = 1'b1;
			end
			ITEM_GOOD: begin
				priority if (mid_item.score >= cfg.occupied_level) begin
					target = PRES_OCCUPIED;
				end else if (mid_item.score <= cfg.vacant_level) begin
					target = PRES_VACANT;
				end else begin
					target = current_q;
				end
				priority if (target == current_q) begin
					pending_d  = target;
					pend_cnt_d = 8'd0;
				end else if (target != pending_q) begin
					pending_d  = target;
					pend_cnt_d = 8'd1;
				end else begin
					pend_cnt_d = pend_cnt_q + 8'd1;
				end
				if (pend_cnt_d >= need) begin
					current_d  = pending_d;
					pend_cnt_d = 8'd0;
				end
				res_d.accepted       = 1'b1;
				res_d.presence       = current_d;
				res_d.activity_score = mid_item.score;
			end
			default: begin
				res_d.accepted = 1'b0;
			end
		endcase
	end

	// presence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q  <= PRES_UNKNOWN;
			pending_q  <= PRES_UNKNOWN;
			pend_cnt_q <= 8'd0;
		end else if (mid_pop) begin
			current_q  <= current_d;
			pending_q  <= pending_d;
			pend_cnt_q <= pend_cnt_d;
		end
	end

	// two-entry result buffer
	assign wr_idx = head_q ^ cnt_q[0];

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			ob_q[wr_idx] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (take_out) begin
				head_q <= ~head_q;
			end
			unique case ({mid_pop, take_out})
				2'b10:   cnt_q <= cnt_q + OutCw'(1);
				2'b01:   cnt_q <= cnt_q - OutCw'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign empty  = (cnt_q == '0);
	assign result = ob_q[head_q];

endmodule
`default_nettype wire

// ===== tb/presence_checker.sv =====
`timescale 1ns / 1ps
// watches the three channels, predicts every presence result and compares it
module presence_checker import phc_pkg::*; #(
	parameter cfg_t RESET_CFG = '0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  in_item_t             window,
	input  logic                 empty,
	input  logic                 pop,
	input  out_item_t            result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	output int                   mismatches,
	output int                   awaited_count
);

	// predicted copy of the registers and the debounce state
	cfg_t       regs;
	presence_t  cur_pres;
	presence_t  pend_pres;
	logic [7:0] pend_wins;
	out_item_t  awaited[$];

	// weighted, saturated motion score in q1.16
	function automatic logic [16:0] window_score(input in_item_t w);
		logic [63:0] vpart;
		logic [63:0] cpart;
		logic [63:0] sum;
		vpart = (64'(w.window_variance) * 64'(regs.variance_gain)) >> 24;
		cpart = (64'(w.window_cv) * 64'(regs.cv_gain)) >> 16;
		if (vpart > 64'(PART_CAP)) vpart = 64'(PART_CAP);
		if (cpart > 64'(PART_CAP)) cpart = 64'(PART_CAP);
		sum = (vpart * 64'(WEIGHT_VAR) + cpart * 64'(WEIGHT_CV)) >> 16;
		if (sum > 64'(SCORE_ONE)) sum = 64'(SCORE_ONE);
		return sum[16:0];
	endfunction

	// one window through quality gate, hysteresis and confirmation
	function automatic out_item_t classify_window(input in_item_t w);
		out_item_t   r;
		presence_t   target;
		logic [16:0] score;
		logic [7:0]  need;
		r = '0;
		// levels not ordered: nothing changes
		if (regs.occupied_level <= regs.vacant_level) return r;
		r.accepted = 1'b1;
		if (w.quality_invalid || w.sample_total < regs.least_samples ||
				$signed(w.signal_rssi) < $signed(regs.least_rssi)) begin
			cur_pres  = PRES_UNKNOWN;
			pend_pres = PRES_UNKNOWN;
			pend_wins = '0;
			return r;
		end
		score  = window_score(w);
		target = cur_pres;
		if (score >= regs.occupied_level) target = PRES_OCCUPIED;
		else if (score <= regs.vacant_level) target = PRES_VACANT;
		if (target == cur_pres) begin
			pend_pres = target;
			pend_wins = '0;
		end else if (target != pend_pres) begin
			pend_pres = target;
			pend_wins = 8'd1;
		end else begin
			pend_wins = pend_wins + 8'd1;
		end
		need = (regs.confirm_count == 8'd0) ? 8'd1 : regs.confirm_count;
		if (pend_wins >= need) begin
			cur_pres  = pend_pres;
			pend_wins = '0;
		end
		r.presence       = cur_pres;
		r.activity_score = score;
		return r;
	endfunction

	task automatic compare_field(input string what, input logic [16:0] want,
			input logic [16:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// channel monitor: results are retired before a new window is predicted
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			regs       = RESET_CFG;
			cur_pres   = PRES_UNKNOWN;
			pend_pres  = PRES_UNKNOWN;
			pend_wins  = '0;
			mismatches = 0;
			awaited.delete();
			awaited_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_VACANT_LEVEL:   regs.vacant_level   = cfg_data[16:0];
					CFG_OCCUPIED_LEVEL: regs.occupied_level = cfg_data[16:0];
					CFG_VARIANCE_GAIN:  regs.variance_gain  = cfg_data[31:0];
					CFG_CV_GAIN:        regs.cv_gain        = cfg_data[23:0];
					CFG_CONFIRM_COUNT:  regs.confirm_count  = cfg_data[7:0];
					CFG_LEAST_SAMPLES:  regs.least_samples  = cfg_data[15:0];
					CFG_LEAST_RSSI:     regs.least_rssi     = cfg_data[7:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (awaited.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
						$time, result.accepted, result.presence, result.activity_score);
				end else begin
					want = awaited.pop_front();
					compare_field("accepted", 17'(want.accepted), 17'(result.accepted));
					compare_field("presence", 17'(want.presence), 17'(result.presence));
					compare_field("activity_score", want.activity_score,
						result.activity_score);
				end
			end
			if (push && !full) awaited.push_back(classify_window(window));
			awaited_count <= awaited.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the presence classifier
module tb;
	import phc_pkg::*;

	localparam cfg_t RESET_CFG = '{
		vacant_level:   17'd11796,
		occupied_level: 17'd36045,
		variance_gain:  32'd16519105,
		cv_gain:        24'd297891,
		confirm_count:  8'd2,
		least_samples:  16'd8,
		least_rssi:     -8'sd82
	};
	localparam logic [CfgIndexW-1:0] CFG_UNUSED = 3'd7;
	localparam int LATENCY     = 3;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	in_item_t             window = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	out_item_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;
	int                   mismatches;
	int                   awaited_count;

	// settings used to shape stimulus
	cfg_t cfg_now = RESET_CFG;
	int   gap_pct = 0;
	int   stall_pct = 0;
	bit   hold_off = 1'b0;
	int   windows_sent = 0;
	int   quiet_run = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	presence_hysteresis_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.window    (window),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	presence_checker #(.RESET_CFG(RESET_CFG)) pres_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.window        (window),
		.empty         (empty),
		.pop           (pop),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.awaited_count (awaited_count)
	);

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_run <= 0;
		end else if (quiet_run >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_run <= quiet_run + 1;
		end
	end

	// result side: random stalls, and one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic in_item_t make_window(input logic [31:0] v, input logic [23:0] c,
			input logic inv, input logic [15:0] n, input logic signed [7:0] r);
		in_item_t w;
		w.window_variance = v;
		w.window_cv       = c;
		w.quality_invalid = inv;
		w.sample_total    = n;
		w.signal_rssi     = r;
		return w;
	endfunction

	// quality fields that pass the current gate
	function automatic in_item_t good_window(input logic [31:0] v, input logic [23:0] c);
		return make_window(v, c, 1'b0,
			16'($urandom_range(16'hFFFF, cfg_now.least_samples)),
			8'($urandom_range(255, int'($signed(cfg_now.least_rssi)) + 128) - 128));
	endfunction

	// break exactly one quality condition, falling back to the invalid flag
	function automatic in_item_t spoil(input in_item_t w);
		case ($urandom_range(2))
			0: w.quality_invalid = 1'b1;
			1: begin
				if (cfg_now.least_samples != 16'd0)
					w.sample_total = 16'($urandom_range(cfg_now.least_samples - 1, 0));
				else
					w.quality_invalid = 1'b1;
			end
			default: begin
				if ($signed(cfg_now.least_rssi) != -8'sd128)
					w.signal_rssi = 8'($urandom_range(
						int'($signed(cfg_now.least_rssi)) + 127, 0) - 128);
				else
					w.quality_invalid = 1'b1;
			end
		endcase
		return w;
	endfunction

	// one input transaction, with a random gap in front of it
	task automatic offer(input in_item_t w);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		push   <= 1'b1;
		window <= w;
		do @(posedge clk); while (full);
		windows_sent++;
	endtask

	// noise, a lone bad window, or a run of similar windows, sometimes long enough to confirm
	task automatic send_burst();
		in_item_t    w;
		logic [31:0] v;
		logic [23:0] c;
		int          pick;
		int          span;
		int          need;
		pick = $urandom_range(99);
		if (pick < 6) begin
			offer(make_window($urandom(), 24'($urandom()), 1'($urandom()),
				16'($urandom()), 8'($urandom())));
		end else if (pick < 16) begin
			offer(spoil(good_window($urandom(), 24'($urandom()))));
		end else begin
			need = (cfg_now.confirm_count == 8'd0) ? 1 :
				(cfg_now.confirm_count > 8'd10) ? 10 : int'(cfg_now.confirm_count);
			span = $urandom_range(need + 2, 1);
			case ($urandom_range(3))
				0: begin
					v = '0;
					c = '0;
				end
				1: begin
					v = $urandom_range(131071);
					c = '0;
				end
				2: begin
					v = $urandom() >> $urandom_range(31);
					c = 24'($urandom() >> $urandom_range(31, 8));
				end
				default: begin
					v = $urandom_range(65535);
					c = 24'($urandom_range(32767));
				end
			endcase
			repeat (span) begin
				w = good_window(v ^ 32'($urandom_range(1023)), c ^ 24'($urandom_range(255)));
				if ($urandom_range(99) < 4) w = spoil(w);
				offer(w);
			end
		end
	endtask

	task automatic stream(input int n);
		int stop_at;
		stop_at = windows_sent + n;
		while (windows_sent < stop_at) send_burst();
	endtask

	// stop offering until every result is back, then allow for the pipeline
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (awaited_count != 0);
		repeat (LATENCY + 1) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// all registers, unused upper bits filled with junk, plus the unused index
	task automatic cfg_load(input cfg_t c);
		cfg_put(CFG_UNUSED, $urandom());
		cfg_put(CFG_VACANT_LEVEL, {15'($urandom()), c.vacant_level});
		cfg_put(CFG_OCCUPIED_LEVEL, {15'($urandom()), c.occupied_level});
		cfg_put(CFG_VARIANCE_GAIN, c.variance_gain);
		cfg_put(CFG_CV_GAIN, {8'($urandom()), c.cv_gain});
		cfg_put(CFG_CONFIRM_COUNT, {24'($urandom()), c.confirm_count});
		cfg_put(CFG_LEAST_SAMPLES, {16'($urandom()), c.least_samples});
		cfg_put(CFG_LEAST_RSSI, {24'($urandom()), c.least_rssi});
		cfg_valid <= 1'b0;
		cfg_now = c;
	endtask

	task automatic retune(input cfg_t c, input int gap, input int stall);
		settle();
		cfg_load(c);
		gap_pct   = gap;
		stall_pct = stall;
	endtask

	initial begin
		cfg_t     c;
		in_item_t sat;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed windows on reset settings
		offer(make_window(32'd0, 24'd0, 1'b0, 16'd8, -8'sd82));
		offer(make_window(32'd0, 24'd0, 1'b0, 16'd8, -8'sd82));
		offer(make_window('1, '1, 1'b0, 16'hFFFF, 8'sd127));
		offer(make_window(32'd40000, 24'd0, 1'b0, 16'd100, -8'sd50));
		offer(make_window('1, '1, 1'b0, 16'hFFFF, 8'sd127));
		offer(make_window('1, '1, 1'b0, 16'hFFFF, 8'sd127));
		offer(make_window(32'd40000, 24'd0, 1'b0, 16'd100, -8'sd50));
		offer(make_window(32'd0, 24'd0, 1'b0, 16'd100, -8'sd50));
		offer(make_window('1, '1, 1'b0, 16'hFFFF, 8'sd127));
		offer(make_window('1, '1, 1'b1, 16'hFFFF, 8'sd127));
		offer(make_window(32'd0, 24'd0, 1'b0, 16'd7, 8'sd0));
		offer(make_window(32'd0, 24'd0, 1'b0, 16'd0, 8'sd0));
		offer(make_window(32'd0, 24'd0, 1'b0, 16'd500, -8'sd83));
		offer(make_window(32'd0, 24'd0, 1'b0, 16'd500, -8'sd128));
		offer(make_window(32'd0, 24'd20000, 1'b0, 16'd8, -8'sd82));
		offer(make_window(32'd0, '1, 1'b0, 16'd8, -8'sd82));
		offer(make_window('1, 24'd0, 1'b0, 16'd8, -8'sd82));
		offer(make_window(32'd1, 24'd1, 1'b0, 16'h8000, 8'sd127));
		offer(make_window(32'h8000_0000, 24'h80_0000, 1'b0, 16'h8000, 8'sd1));
		offer(make_window(32'd0, 24'd0, 1'b1, 16'd0, -8'sd128));

		// single-window confirmation, no idling, with a full drain midway
		c = RESET_CFG;
		c.confirm_count = 8'd1;
		retune(c, 0, 0);
		stream(75);
		settle();
		stream(75);

		// zero confirmation acts as one, sender idling
		c.confirm_count = 8'd0;
		retune(c, 52, 0);
		stream(150);

		// longer confirmation, receiver stalling, with one long hold-off
		c.confirm_count = 8'd4;
		retune(c, 0, 52);
		hold_off = 1'b1;
		stream(150);

		// random ordered levels and gains, both sides idling
		c.vacant_level   = 17'($urandom_range(40000));
		c.occupied_level = 17'($urandom_range(65536, int'(c.vacant_level) + 1));
		c.variance_gain  = $urandom_range(33000000, 8000000);
		c.cv_gain        = 24'($urandom_range(600000, 100000));
		c.confirm_count  = 8'd3;
		c.least_samples  = 16'($urandom_range(100));
		c.least_rssi     = 8'($urandom_range(80) - 110);
		retune(c, 33, 33);
		stream(200);

		// upper extremes: full gains, longest confirmation, strictest gate
		c = '{vacant_level: 17'd0, occupied_level: 17'd65536, variance_gain: '1,
			cv_gain: '1, confirm_count: 8'd255, least_samples: 16'hFFFF,
			least_rssi: 8'sd127};
		retune(c, 0, 52);
		sat = make_window('1, '1, 1'b1, 16'hFFFF, 8'sd127);
		offer(sat);
		sat.quality_invalid = 1'b0;
		repeat (260) offer(sat);
		stream(40);

		// lower extremes: zero gains, no confirmation wait, open gate
		c = '{vacant_level: 17'd0, occupied_level: 17'd1, variance_gain: '0,
			cv_gain: '0, confirm_count: 8'd1, least_samples: 16'd0,
			least_rssi: -8'sd128};
		retune(c, 52, 0);
		stream(80);

		// levels equal, then reversed: windows rejected
		c = RESET_CFG;
		c.vacant_level   = 17'd30000;
		c.occupied_level = 17'd30000;
		retune(c, 0, 0);
		stream(30);
		c.vacant_level   = 17'd131071;
		c.occupied_level = 17'd0;
		retune(c, 33, 33);
		stream(30);

		// levels beyond full scale
		c.vacant_level   = 17'd70000;
		c.occupied_level = 17'd131071;
		retune(c, 0, 0);
		stream(50);

		// back to reset settings, both sides idling
		retune(RESET_CFG, 33, 33);
		stream(150);

		settle();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
